### hw/rtl/timed_message_queue_assert.svh
// assertion macros used by the port-level queue checker
`ifndef TIMED_MESSAGE_QUEUE_ASSERT_SVH
`define TIMED_MESSAGE_QUEUE_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define TMQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define TMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tmq_pkg.sv
// shared types and constants of the timed message queue
`default_nettype none

package tmq_pkg;

  localparam int unsigned DepthDef      = 16;
  localparam int unsigned HandleBitsDef = 8;
  localparam int unsigned TimeBitsDef   = 48;

  typedef enum logic [1:0] {
    MODE_ENQ       = 2'd0,
    MODE_POLL      = 2'd1,
    MODE_QUIT_SAFE = 2'd2,
    MODE_QUIT_ALL  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED     = 3'd0,
    ST_DROPPED_FULL = 3'd1,
    ST_IGNORED_QUIT = 3'd2,
    ST_DELIVERED    = 3'd3,
    ST_NOT_DUE      = 3'd4,
    ST_EMPTY        = 3'd5,
    ST_REMOVED      = 3'd6,
    ST_NONE_REMOVED = 3'd7
  } status_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic enq;       // insert new entry, later entries move right
    logic shl;       // every cell takes its right neighbour
    logic mark;      // latch the removal flag
    logic force_all; // removal flag set on every valid entry
  } cell_op_t;

endpackage

`default_nettype wire

### hw/rtl/tmq_cell.sv
// one entry of the sorted chain: handle, due time, occupancy and removal flag
`default_nettype none

module tmq_cell #(
  parameter int unsigned HANDLE_BITS = tmq_pkg::HandleBitsDef,
  parameter int unsigned TIME_BITS   = tmq_pkg::TimeBitsDef
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  tmq_pkg::cell_op_t     op_i,
  input  wire [HANDLE_BITS-1:0] new_handle_i,
  input  wire [TIME_BITS-1:0]   new_due_i,
  input  wire [TIME_BITS-1:0]   now_i,
  input  wire                   left_valid_i,
  input  wire                   left_gt_i,
  input  wire [HANDLE_BITS-1:0] left_handle_i,
  input  wire [TIME_BITS-1:0]   left_due_i,
  input  wire                   right_valid_i,
  input  wire                   right_rm_i,
  input  wire [HANDLE_BITS-1:0] right_handle_i,
  input  wire [TIME_BITS-1:0]   right_due_i,
  output logic                  valid_o,
  output logic                  rm_o,
  output logic                  gt_o,
  output logic                  hit_o,
  output logic [HANDLE_BITS-1:0] handle_o,
  output logic [TIME_BITS-1:0]   due_o
);

  logic                   valid_q, valid_d;
  logic                   rm_q, rm_d;
  logic [HANDLE_BITS-1:0] handle_q, handle_d;
  logic [TIME_BITS-1:0]   due_q, due_d;
  logic                   gt;
  logic                   hit;
  logic                   ins_here;

  // new entry goes in front of this one
  assign gt  = valid_q && ((new_due_i == '0) || (new_due_i < due_q));
  assign hit = valid_q && (op_i.force_all || (due_q > now_i));
  // first cell that is either later than the new entry or the first free one
  assign ins_here = left_valid_i && !left_gt_i && (gt || !valid_q);

  always_comb begin
    valid_d  = valid_q;
    rm_d     = rm_q;
    handle_d = handle_q;
    due_d    = due_q;
    if (op_i.shl) begin
      valid_d  = right_valid_i;
      rm_d     = right_rm_i;
      handle_d = right_handle_i;
      due_d    = right_due_i;
    end else if (op_i.enq) begin
      if (left_gt_i) begin
        valid_d  = 1'b1;
        handle_d = left_handle_i;
        due_d    = left_due_i;
      end else if (ins_here) begin
        valid_d  = 1'b1;
        handle_d = new_handle_i;
        due_d    = new_due_i;
      end
    end else if (op_i.mark) begin
      rm_d = hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rm_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      rm_q    <= rm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    handle_q <= handle_d;
    due_q    <= due_d;
  end

  assign valid_o  = valid_q;
  assign rm_o     = rm_q;
  assign gt_o     = gt;
  assign hit_o    = hit;
  assign handle_o = handle_q;
  assign due_o    = due_q;

endmodule

`default_nettype wire

### hw/rtl/timed_message_queue.sv
// timed message queue: chain of sorted cells with output register
//
//   beat     direction  handshake               fields
//   input    in         in_valid_i / in_stall_o  mode, handle, due_time, now_time
//   result   out        out_valid_o / out_stall_i status, out_handle, wait_time, last
//
// enqueue, poll and a quit that removes nothing go straight to the output register; one beat
// accepted per cycle while results are taken; the cells compare in parallel.
// a quit with removals drains the chain through cell 0: kept entries are shifted out
// unreported, then each removed entry is reported in order, input stalled meanwhile.
// after reset the queue is empty and open; no clearing pass.
// a stalled result holds the output register; input stalls while that register
// is held or a drain runs.
`default_nettype none

module timed_message_queue #(
  parameter int unsigned DEPTH       = tmq_pkg::DepthDef,
  parameter int unsigned HANDLE_BITS = tmq_pkg::HandleBitsDef,
  parameter int unsigned TIME_BITS   = tmq_pkg::TimeBitsDef
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire [1:0]              mode_i,
  input  wire [HANDLE_BITS-1:0]  handle_i,
  input  wire [TIME_BITS-1:0]    due_time_i,
  input  wire [TIME_BITS-1:0]    now_time_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output logic [2:0]             status_o,
  output logic [HANDLE_BITS-1:0] out_handle_o,
  output logic [TIME_BITS-1:0]   wait_time_o,
  output logic                   last_o
);

  logic [DEPTH-1:0]       c_valid;
  logic [DEPTH-1:0]       c_rm;
  logic [DEPTH-1:0]       c_gt;
  logic [DEPTH-1:0]       c_hit;
  logic [HANDLE_BITS-1:0] c_handle [DEPTH];
  logic [TIME_BITS-1:0]   c_due    [DEPTH];

  tmq_pkg::cell_op_t op;
  tmq_pkg::mode_e    mode;
  tmq_pkg::status_e  st;

  logic                   quit_q, quit_d;
  logic                   busy_q, busy_d;
  logic                   out_valid_q, out_valid_d;
  tmq_pkg::status_e       status_q;
  logic [HANDLE_BITS-1:0] handle_q, oh;
  logic [TIME_BITS-1:0]   wait_q, wt;
  logic                   last_q, lst;
  logic                   load;
  logic                   out_free;
  logic                   accept;

  assign mode       = tmq_pkg::mode_e'(mode_i);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy_q || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                   lv, lg, rv, rr;
    logic [HANDLE_BITS-1:0] lh, rh;
    logic [TIME_BITS-1:0]   ld, rd;

    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign lg = 1'b0;
      assign lh = '0;
      assign ld = '0;
    end else begin : g_left
      assign lv = c_valid[i-1];
      assign lg = c_gt[i-1];
      assign lh = c_handle[i-1];
      assign ld = c_due[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign rr = 1'b0;
      assign rh = '0;
      assign rd = '0;
    end else begin : g_right
      assign rv = c_valid[i+1];
      assign rr = c_rm[i+1];
      assign rh = c_handle[i+1];
      assign rd = c_due[i+1];
    end

    tmq_cell #(
      .HANDLE_BITS(HANDLE_BITS),
      .TIME_BITS  (TIME_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (op),
      .new_handle_i  (handle_i),
      .new_due_i     (due_time_i),
      .now_i         (now_time_i),
      .left_valid_i  (lv),
      .left_gt_i     (lg),
      .left_handle_i (lh),
      .left_due_i    (ld),
      .right_valid_i (rv),
      .right_rm_i    (rr),
      .right_handle_i(rh),
      .right_due_i   (rd),
      .valid_o       (c_valid[i]),
      .rm_o          (c_rm[i]),
      .gt_o          (c_gt[i]),
      .hit_o         (c_hit[i]),
      .handle_o      (c_handle[i]),
      .due_o         (c_due[i])
    );
  end

  always_comb begin
    op           = '0;
    op.force_all = (mode == tmq_pkg::MODE_QUIT_ALL);
    load         = 1'b0;
    st           = tmq_pkg::ST_ACCEPTED;
    oh           = '0;
    wt           = '0;
    lst          = 1'b1;
    quit_d       = quit_q;
    busy_d       = busy_q;
    if (busy_q) begin
      // drain: kept entries leave silently, marked ones go out in order
      if (out_free) begin
        op.shl = 1'b1;
        if (c_rm[0]) begin
          load = 1'b1;
          st   = tmq_pkg::ST_REMOVED;
          oh   = c_handle[0];
          lst  = !c_rm[1];
          if (!c_rm[1]) begin
            busy_d = 1'b0;
          end
        end
      end
    end else if (accept) begin
      load = 1'b1;
      if (quit_q) begin
        st = tmq_pkg::ST_IGNORED_QUIT;
      end else begin
        case (mode)
          tmq_pkg::MODE_ENQ: begin
            if (c_valid[DEPTH-1]) begin
              st = tmq_pkg::ST_DROPPED_FULL;
            end else begin
              op.enq = 1'b1;
            end
          end
          tmq_pkg::MODE_POLL: begin
            if (!c_valid[0]) begin
              st = tmq_pkg::ST_EMPTY;
            end else if (now_time_i < c_due[0]) begin
              st = tmq_pkg::ST_NOT_DUE;
              wt = c_due[0] - now_time_i;
            end else begin
              st     = tmq_pkg::ST_DELIVERED;
              oh     = c_handle[0];
              op.shl = 1'b1;
            end
          end
          tmq_pkg::MODE_QUIT_SAFE, tmq_pkg::MODE_QUIT_ALL: begin
            quit_d = 1'b1;
            if (|c_hit) begin
              op.mark = 1'b1;
              busy_d  = 1'b1;
              load    = 1'b0;
            end else begin
              st = tmq_pkg::ST_NONE_REMOVED;
            end
          end
          default: begin
            load = 1'b0;
          end
        endcase
      end
    end
  end

  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quit_q      <= 1'b0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      quit_q      <= quit_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= st;
      handle_q <= oh;
      wait_q   <= wt;
      last_q   <= lst;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign out_handle_o = handle_q;
  assign wait_time_o  = wait_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

### hw/rtl/tmq_checker.sv
// port-level checks of the timed message queue, bound to the top level
`default_nettype none

`include "timed_message_queue_assert.svh"

module tmq_checker #(
  parameter int unsigned TIME_BITS = tmq_pkg::TimeBitsDef
) (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_stall_o,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input wire [2:0]           status_o,
  input wire [TIME_BITS-1:0] wait_time_o,
  input wire                 last_o
);

  // a stalled result beat stays presented
  `TMQ_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(last_o), "stalled result beat changed")

  // no input beat taken while the output register is blocked
  `TMQ_ASSERT_NOW(a_no_accept_blocked, in_valid_i && !in_stall_o, !(out_valid_o && out_stall_i), "input taken with result stalled")

  // a removal run keeps the input closed until its last beat
  `TMQ_ASSERT_NOW(a_drain_stall, out_valid_o && (status_o == tmq_pkg::ST_REMOVED) && !last_o, in_stall_o, "input opened inside a removal run")

  // only a not-due report carries a wait time, and never zero
  `TMQ_ASSERT_NOW(a_wait_time, out_valid_o, (status_o == tmq_pkg::ST_NOT_DUE) == (wait_time_o != '0), "wait time disagrees with status")

endmodule

bind timed_message_queue tmq_checker #(
  .TIME_BITS(TIME_BITS)
) u_tmq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .status_o   (status_o),
  .wait_time_o(wait_time_o),
  .last_o     (last_o)
);

`default_nettype wire

### dv/tmq_checker.sv
// checker for the timed message queue: keeps its own image of the queue and compares results
module tmq_scoreboard
  import tmq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef,
  parameter int unsigned HB    = HandleBitsDef,
  parameter int unsigned TB    = TimeBitsDef
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  input  wire          in_stall_i,
  input  wire [1:0]    mode_i,
  input  wire [HB-1:0] handle_i,
  input  wire [TB-1:0] due_time_i,
  input  wire [TB-1:0] now_time_i,
  input  wire          out_valid_i,
  input  wire          out_stall_i,
  input  wire [2:0]    status_i,
  input  wire [HB-1:0] out_handle_i,
  input  wire [TB-1:0] wait_time_i,
  input  wire          last_i,
  output int           errors_o,
  output int           pending_o,
  output int           checked_o
);

  typedef struct {
    status_e       status;
    logic [HB-1:0] handle;
    logic [TB-1:0] wait_ms;
    logic          is_last;
  } result_t;

  logic [HB-1:0] img_handle [0:DEPTH-1];
  logic [TB-1:0] img_due    [0:DEPTH-1];
  int unsigned   img_count;
  bit            img_quit;
  result_t       owed_results [$];
  result_t       exp_r;

  initial begin
    img_count = 0;
    img_quit  = 1'b0;
    errors_o  = 0;
    pending_o = 0;
    checked_o = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("tmq_checker: mismatch on result %0d: %s", checked_o, msg);
    errors_o++;
  endtask

  function automatic void owe(input status_e s, input logic [HB-1:0] h,
                              input logic [TB-1:0] w, input logic l);
    result_t r;
    r.status  = s;
    r.handle  = h;
    r.wait_ms = w;
    r.is_last = l;
    owed_results.push_back(r);
  endfunction

  // next state of the queue image and the results one beat causes
  task automatic advance_queue_image(input mode_e cmd, input logic [HB-1:0] hdl,
                                     input logic [TB-1:0] due, input logic [TB-1:0] now);
    int unsigned pos;
    int unsigned i;
    if (img_quit) begin
      owe(ST_IGNORED_QUIT, '0, '0, 1'b1);
    end else if (cmd == MODE_ENQ) begin
      if (img_count >= DEPTH) begin
        owe(ST_DROPPED_FULL, '0, '0, 1'b1);
      end else begin
        // zero or earlier than the head goes in front, ties go behind
        pos = 0;
        if (img_count != 0 && due != '0 && due >= img_due[0]) begin
          pos = 1;
          while (pos < img_count && due >= img_due[pos]) pos++;
        end
        for (i = img_count; i > pos; i--) begin
          img_handle[i] = img_handle[i-1];
          img_due[i]    = img_due[i-1];
        end
        img_handle[pos] = hdl;
        img_due[pos]    = due;
        img_count++;
        owe(ST_ACCEPTED, '0, '0, 1'b1);
      end
    end else if (cmd == MODE_POLL) begin
      if (img_count == 0) begin
        owe(ST_EMPTY, '0, '0, 1'b1);
      end else if (now < img_due[0]) begin
        owe(ST_NOT_DUE, '0, img_due[0] - now, 1'b1);
      end else begin
        owe(ST_DELIVERED, img_handle[0], '0, 1'b1);
        for (i = 1; i < img_count; i++) begin
          img_handle[i-1] = img_handle[i];
          img_due[i-1]    = img_due[i];
        end
        img_count--;
      end
    end else begin
      img_quit = 1'b1;
      pos = 0;
      if (cmd == MODE_QUIT_SAFE) begin
        while (pos < img_count && img_due[pos] <= now) pos++;
      end
      if (pos == img_count) begin
        owe(ST_NONE_REMOVED, '0, '0, 1'b1);
      end else begin
        for (i = pos; i < img_count; i++) owe(ST_REMOVED, img_handle[i], '0, i + 1 == img_count);
      end
      img_count = pos;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // results first: a beat taken at this edge cannot have produced one yet
      if (out_valid_i && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, status %0d handle %0h", status_i,
                                    out_handle_i));
        end else begin
          exp_r = owed_results.pop_front();
          if (status_i !== exp_r.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_i, exp_r.status));
          if (out_handle_i !== exp_r.handle)
            report_mismatch($sformatf("handle %0h, expected %0h", out_handle_i, exp_r.handle));
          if (wait_time_i !== exp_r.wait_ms)
            report_mismatch($sformatf("wait %0d, expected %0d", wait_time_i, exp_r.wait_ms));
          if (last_i !== exp_r.is_last)
            report_mismatch($sformatf("last %0b, expected %0b", last_i, exp_r.is_last));
        end
        checked_o++;
      end
      if (in_valid_i && !in_stall_i)
        advance_queue_image(mode_e'(mode_i), handle_i, due_time_i, now_time_i);
      pending_o = owed_results.size();
    end
  end

endmodule

### dv/tb.sv
// testbench top for the timed message queue: clock, reset, stimulus and verdict
module tb;
  import tmq_pkg::*;

  localparam int unsigned DEPTH = DepthDef;
  localparam int unsigned HB    = HandleBitsDef;
  localparam int unsigned TB    = TimeBitsDef;

  localparam int RANDOM_BEATS = 74;
  localparam int HOLD_CYCLES  = 60;
  localparam int STALL_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 24;
  localparam logic [TB-1:0] TIME_MAX = '1;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  logic [1:0]    mode_i;
  logic [HB-1:0] handle_i;
  logic [TB-1:0] due_time_i;
  logic [TB-1:0] now_time_i;
  logic          out_valid_o;
  logic          out_stall_i;
  logic [2:0]    status_o;
  logic [HB-1:0] out_handle_o;
  logic [TB-1:0] wait_time_o;
  logic          last_o;

  int    errors;
  int    pending;
  int    checked;
  int    beats_sent;
  int    idle_cycles;
  bit    quiet;
  bit    hold_req;
  string quit_desc;

  timed_message_queue #(
    .DEPTH      (DEPTH),
    .HANDLE_BITS(HB),
    .TIME_BITS  (TB)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .handle_i    (handle_i),
    .due_time_i  (due_time_i),
    .now_time_i  (now_time_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .out_handle_o(out_handle_o),
    .wait_time_o (wait_time_o),
    .last_o      (last_o)
  );

  tmq_scoreboard #(
    .DEPTH(DEPTH),
    .HB   (HB),
    .TB   (TB)
  ) tmq_mon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .mode_i      (mode_i),
    .handle_i    (handle_i),
    .due_time_i  (due_time_i),
    .now_time_i  (now_time_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status_o),
    .out_handle_i(out_handle_o),
    .wait_time_i (wait_time_o),
    .last_i      (last_o),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [TB-1:0] any_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TB-1:0];
  endfunction

  // offer one beat, wait for it to be taken, then maybe leave a gap
  task automatic send_beat(input mode_e m, input logic [HB-1:0] h,
                           input logic [TB-1:0] due, input logic [TB-1:0] now);
    in_valid_i <= 1'b1;
    mode_i     <= m;
    handle_i   <= h;
    due_time_i <= due;
    now_time_i <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: no beat moved for %0d cycles, %0d results still owed", idle_cycles,
                 pending);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [TB-1:0] clock_ms;
    logic [TB-1:0] prev_due;
    logic [TB-1:0] due;
    logic [TB-1:0] now;
    int            enq_pct;
    int            n;
    int            sel;

    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    mode_i     <= MODE_ENQ;
    handle_i   <= '0;
    due_time_i <= '0;
    now_time_i <= '0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    beats_sent = 0;
    clock_ms   = TB'(1000);
    prev_due   = TB'(1000);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty poll, ordering corners, both ends of the time range
    send_beat(MODE_POLL, '0, '0, '0);
    send_beat(MODE_ENQ, 8'h00, TIME_MAX, '0);
    send_beat(MODE_ENQ, 8'hff, TB'(100), '0);
    send_beat(MODE_ENQ, 8'h55, TB'(100), '0);
    send_beat(MODE_ENQ, 8'haa, '0, TIME_MAX);
    send_beat(MODE_POLL, '0, TIME_MAX, '0);
    send_beat(MODE_POLL, '0, '0, TB'(99));
    send_beat(MODE_POLL, '1, '0, TB'(100));
    send_beat(MODE_POLL, '0, '0, TIME_MAX);
    send_beat(MODE_POLL, '1, TIME_MAX, '0);
    // fill to capacity, the last one is dropped
    for (n = 0; n < DEPTH; n++)
      send_beat(MODE_ENQ, HB'($urandom), clock_ms + $urandom_range(0, 300), any_time());

    // random: poll-heavy and enqueue-heavy stretches in turn, starting on a full queue
    hold_req = 1'b1;
    quiet    = 1'b1;
    enq_pct  = 30;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 20) quiet = 1'b0;
      if (n == RANDOM_BEATS - 30) quiet = 1'b1;
      if (n % 20 == 0 && n != 0) enq_pct = 100 - enq_pct;
      sel = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < enq_pct) begin
        case (sel)
          0:       due = '0;
          1:       due = any_time();
          2:       due = prev_due;
          3:       due = TIME_MAX;
          default: due = clock_ms + $urandom_range(0, 300);
        endcase
        prev_due = due;
        send_beat(MODE_ENQ, HB'($urandom), due, any_time());
      end else begin
        case (sel)
          0:       now = any_time();
          1:       now = '0;
          default: now = clock_ms + $urandom_range(0, 300);
        endcase
        send_beat(MODE_POLL, HB'($urandom), any_time(), now);
      end
      clock_ms = clock_ms + $urandom_range(0, 25);
    end

    // stock the queue, then one quit of a random kind
    for (n = 0; n < 6; n++)
      send_beat(MODE_ENQ, HB'($urandom), clock_ms + $urandom_range(0, 300), '0);
    case ($urandom_range(0, 2))
      0: begin
        quit_desc = "forced quit";
        send_beat(MODE_QUIT_ALL, HB'($urandom), any_time(), any_time());
      end
      1: begin
        quit_desc = "safe quit splitting the queue";
        send_beat(MODE_QUIT_SAFE, '0, '0, clock_ms + 150);
      end
      default: begin
        quit_desc = "safe quit with nothing removed";
        send_beat(MODE_QUIT_SAFE, '1, '1, TIME_MAX);
      end
    endcase
    // everything after the quit is refused
    send_beat(MODE_ENQ, HB'($urandom), TB'(5), '0);
    send_beat(MODE_POLL, '0, '0, TIME_MAX);
    send_beat(MODE_QUIT_SAFE, '0, '0, '0);
    send_beat(MODE_QUIT_ALL, '0, '0, '0);
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("tb: %0d beats in, %0d results checked; full-queue drops, a long hold-off, %s",
             beats_sent, checked, quit_desc);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/tmq_pkg.sv
hw/rtl/tmq_cell.sv
hw/rtl/timed_message_queue.sv
hw/rtl/tmq_checker.sv
dv/tmq_checker.sv
dv/tb.sv
